@@ hdl/strobed_ram_with_boot_overlay_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the strobed RAM with boot overlay.
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STROBED_RAM_WITH_BOOT_OVERLAY_UNIT_DEFINES_SVH
`define STROBED_RAM_WITH_BOOT_OVERLAY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbo_pkg.sv @@
// ----------------------------------------------------------------------------
// sbo_pkg
// Shared constants, types and the bootstrap table of the strobed RAM.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int ADDR_BITS = 15;
    localparam int WORD_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;

    localparam int IN_BITS      = 1 + ADDR_BITS + WORD_BITS + 2;
    localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

    localparam int RST_POS  = 0;
    localparam int ADDR_LSB = 1;
    localparam int DATA_LSB = ADDR_LSB + ADDR_BITS;
    localparam int RD_POS   = DATA_LSB + WORD_BITS;
    localparam int WR_POS   = RD_POS + 1;

    localparam logic [1:0] NEVER_SEEN = 2'd2;
    localparam logic [1:0] SHUT_DONE  = 2'd3;
    localparam logic [1:0] SHUT_ARMED = 2'd1;
    localparam logic [1:0] SHUT_IDLE  = 2'd0;

    localparam logic [ADDR_BITS-1:0] OVL_FIRST = ADDR_BITS'(12'o7400);
    localparam logic [ADDR_BITS-1:0] OVL_LAST  = ADDR_BITS'(12'o7424);
    localparam logic [ADDR_BITS-1:0] OVL_ARM   = ADDR_BITS'(12'o7416);
    localparam int OVL_IDX_BITS = 5;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] wr_data;
    } sbo_ram_cmd_t;

    typedef struct packed {
        logic                 from_overlay;
        logic [WORD_BITS-1:0] ovl_word;
        logic                 fwd;
        logic [WORD_BITS-1:0] fwd_data;
    } sbo_rsp_info_t;

    function automatic logic [WORD_BITS-1:0] boot_word(input logic [OVL_IDX_BITS-1:0] idx);
        logic [11:0] w;
        begin
            case (idx)
                5'd0:    w = 12'o7240;
                5'd1:    w = 12'o1224;
                5'd2:    w = 12'o3010;
                5'd3:    w = 12'o1217;
                5'd4:    w = 12'o3410;
                5'd5:    w = 12'o1220;
                5'd6:    w = 12'o3410;
                5'd7:    w = 12'o1221;
                5'd8:    w = 12'o3410;
                5'd9:    w = 12'o1222;
                5'd10:   w = 12'o3410;
                5'd11:   w = 12'o1223;
                5'd12:   w = 12'o3410;
                5'd13:   w = 12'o7300;
                5'd14:   w = 12'o5624;
                5'd15:   w = 12'o7600;
                5'd16:   w = 12'o6603;
                5'd17:   w = 12'o6622;
                5'd18:   w = 12'o5352;
                5'd19:   w = 12'o5752;
                5'd20:   w = 12'o7750;
                default: w = 12'o0000;
            endcase
            return WORD_BITS'(w);
        end
    endfunction

endpackage

@@ hdl/strobed_ram_with_boot_overlay_unit.sv @@
// A read result passes from the s1 stage to the output register that drives m_tvalid.
// Throughput: one request per cycle unless the RAM is clearing or m_tready stalls.
// Requests that start no read return nothing and occupy no output slot.
// After rst_n is released the RAM is cleared one word a cycle, all 2^ADDR_BITS words
// (32768 at the default size), with s_tready held low throughout.
// ----------------------------------------------------------------------------
// strobed_ram_with_boot_overlay_unit
// Bus-sampled word RAM that returns bootstrap words while its overlay is on.
// ----------------------------------------------------------------------------
`include "strobed_ram_with_boot_overlay_unit_defines.svh"

module strobed_ram_with_boot_overlay_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // reset_level, address, write_data, read_strobe, write_strobe, zero pad
    input  logic [sbo_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sbo_pkg::M_TDATA_BITS-1:0] m_tdata, // read_data
    output logic [0:0]                       m_tuser  // from_overlay
);

    import sbo_pkg::*;

    logic                 clearing_reg, clearing_next;
    logic [ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;

    logic                 accept;
    logic                 stage_free;
    sbo_ram_cmd_t         ram_cmd;
    logic                 info_valid;
    sbo_rsp_info_t        info;
    logic                 ram_wr_en;
    logic [ADDR_BITS-1:0] ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic [WORD_BITS-1:0] ram_rd_data;

    assign s_tready = stage_free && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        clr_addr_next = clearing_reg ? clr_addr_reg + ADDR_BITS'(1) : clr_addr_reg;
        clearing_next = clearing_reg && (clr_addr_reg != '1);

        ram_wr_en   = clearing_reg || ram_cmd.wr_en;
        ram_wr_addr = clearing_reg ? clr_addr_reg : ram_cmd.addr;
        ram_wr_data = clearing_reg ? '0 : ram_cmd.wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    sbo_event u_event (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .reset_level  (s_tdata[RST_POS]),
        .address      (s_tdata[ADDR_LSB +: ADDR_BITS]),
        .write_data   (s_tdata[DATA_LSB +: WORD_BITS]),
        .read_strobe  (s_tdata[RD_POS]),
        .write_strobe (s_tdata[WR_POS]),
        .ram_cmd      (ram_cmd),
        .info_valid   (info_valid),
        .info         (info)
    );

    sbo_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.addr),
        .rd_data (ram_rd_data)
    );

    sbo_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .info_valid  (info_valid),
        .info        (info),
        .ram_rd_data (ram_rd_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .stage_free  (stage_free)
    );

    `SBO_ASSERT_SAME(a_no_request_while_clearing, clearing_reg, !accept,
        "request accepted during the RAM clearing pass")
    `SBO_ASSERT_SAME(a_clear_writes_zero, clearing_reg,
        ram_wr_en && (ram_wr_data == '0) && (ram_wr_addr == clr_addr_reg),
        "clearing pass did not write zero at its sweep address")
    `SBO_ASSERT_SAME(a_clear_ends_at_top, $fell(clearing_reg), $past(clr_addr_reg) == '1,
        "clearing pass ended before the last RAM word")
    `SBO_ASSERT_NEXT(a_read_reaches_stage, accept && info_valid && !info.fwd,
        $past(ram_cmd.rd_en), "started read issued no RAM read")

endmodule

@@ hdl/sbo_ram.sv @@
// ----------------------------------------------------------------------------
// sbo_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sbo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/sbo_event.sv @@
// ----------------------------------------------------------------------------
// sbo_event
// Finds write and read starts from the bus sample and keeps overlay state.
// ----------------------------------------------------------------------------
module sbo_event (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            reset_level,
    input  logic [sbo_pkg::ADDR_BITS-1:0]   address,
    input  logic [sbo_pkg::WORD_BITS-1:0]   write_data,
    input  logic                            read_strobe,
    input  logic                            write_strobe,
    output sbo_pkg::sbo_ram_cmd_t           ram_cmd,
    output logic                            info_valid,
    output sbo_pkg::sbo_rsp_info_t          info
);

    import sbo_pkg::*;

    logic [1:0]           prior_rd_reg, prior_rd_next;
    logic [1:0]           prior_wr_reg, prior_wr_next;
    logic [ADDR_BITS-1:0] prior_addr_reg, prior_addr_next;
    logic                 overlay_on_reg, overlay_on_next;
    logic [1:0]           shut_cnt_reg, shut_cnt_next;

    logic                 addr_diff;
    logic                 wr_event;
    logic                 wr_begin;
    logic                 wr_end;
    logic                 rd_begin;
    logic                 ovl_eff;
    logic [1:0]           cnt_eff;
    logic [1:0]           cnt_armed;
    logic [1:0]           cnt_stepped;
    logic                 ovl_read;
    logic                 in_window;
    logic [ADDR_BITS-1:0] ovl_offset;

    always_comb
    begin
        addr_diff = (address != prior_addr_reg);
        wr_event  = ({1'b0, write_strobe} != prior_wr_reg) || addr_diff;
        wr_begin  = wr_event && write_strobe;
        wr_end    = wr_event && !write_strobe;
        rd_begin  = read_strobe &&
                    (({1'b0, read_strobe} != prior_rd_reg) || wr_end || addr_diff);

        ovl_eff  = reset_level || overlay_on_reg;
        cnt_eff  = reset_level ? SHUT_IDLE : shut_cnt_reg;
        ovl_read = rd_begin && ovl_eff;

        cnt_armed   = (ovl_read && (address == OVL_ARM)) ? SHUT_ARMED : cnt_eff;
        cnt_stepped = (ovl_read && (cnt_armed != SHUT_IDLE) && (cnt_armed != SHUT_DONE))
                      ? cnt_armed + 2'd1 : cnt_armed;

        in_window  = (address >= OVL_FIRST) && (address <= OVL_LAST);
        ovl_offset = address - OVL_FIRST;

        prior_rd_next   = accept ? {1'b0, read_strobe} : prior_rd_reg;
        prior_wr_next   = accept ? {1'b0, write_strobe} : prior_wr_reg;
        prior_addr_next = accept ? address : prior_addr_reg;
        shut_cnt_next   = accept ? cnt_stepped : shut_cnt_reg;
        overlay_on_next = accept ? (ovl_eff && !(ovl_read && (cnt_stepped == SHUT_DONE)))
                                 : overlay_on_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_rd_reg   <= NEVER_SEEN;
            prior_wr_reg   <= NEVER_SEEN;
            prior_addr_reg <= '0;
            overlay_on_reg <= 1'b0;
            shut_cnt_reg   <= SHUT_IDLE;
        end
        else
        begin
            prior_rd_reg   <= prior_rd_next;
            prior_wr_reg   <= prior_wr_next;
            prior_addr_reg <= prior_addr_next;
            overlay_on_reg <= overlay_on_next;
            shut_cnt_reg   <= shut_cnt_next;
        end
    end

    always_comb
    begin
        ram_cmd.wr_en   = accept && wr_begin;
        ram_cmd.rd_en   = accept && rd_begin;
        ram_cmd.addr    = address;
        ram_cmd.wr_data = write_data;

        info_valid        = rd_begin;
        info.from_overlay = ovl_eff && in_window;
        info.ovl_word     = boot_word(ovl_offset[OVL_IDX_BITS-1:0]);
        info.fwd          = wr_begin;
        info.fwd_data     = write_data;
    end

endmodule

@@ hdl/sbo_out.sv @@
// ----------------------------------------------------------------------------
// sbo_out
// Holds a request while its RAM read completes and drives the output register.
// ----------------------------------------------------------------------------
module sbo_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             info_valid,
    input  sbo_pkg::sbo_rsp_info_t           info,
    input  logic [sbo_pkg::WORD_BITS-1:0]    ram_rd_data,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [sbo_pkg::M_TDATA_BITS-1:0] m_tdata, // read_data
    output logic [0:0]                       m_tuser, // from_overlay
    output logic                             stage_free
);

    import sbo_pkg::*;

    logic                 s1_valid_reg, s1_valid_next;
    sbo_rsp_info_t        s1_info_reg, s1_info_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] out_data_reg, out_data_next;
    logic                 out_ovl_reg, out_ovl_next;

    logic                 s1_move;
    logic [WORD_BITS-1:0] s1_word;

    always_comb
    begin
        s1_move    = s1_valid_reg && (!out_valid_reg || m_tready);
        stage_free = !s1_valid_reg || s1_move;

        if (s1_info_reg.from_overlay)
        begin
            s1_word = s1_info_reg.ovl_word;
        end
        else if (s1_info_reg.fwd)
        begin
            s1_word = s1_info_reg.fwd_data;
        end
        else
        begin
            s1_word = ram_rd_data;
        end

        s1_valid_next = accept ? info_valid : (s1_valid_reg && !s1_move);
        s1_info_next  = accept ? info : s1_info_reg;

        out_valid_next = s1_move || (out_valid_reg && !m_tready);
        out_data_next  = s1_move ? s1_word : out_data_reg;
        out_ovl_next   = s1_move ? s1_info_reg.from_overlay : out_ovl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_info_reg  <= s1_info_next;
        out_data_reg <= out_data_next;
        out_ovl_reg  <= out_ovl_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(out_data_reg);
    assign m_tuser  = out_ovl_reg;

endmodule
